### src/positional_list_store_macros.svh
// Assertion macros used by the positional list store datapath
`ifndef POSITIONAL_LIST_STORE_MACROS_SVH
`define POSITIONAL_LIST_STORE_MACROS_SVH
`ifndef SYNTH
`define PLS_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define PLS_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`else
`define PLS_ASSERT(name, prop, msg)
`define PLS_ASSERT_IMP(name, ante, cons, msg)
`endif
`endif

### src/pls_pkg.sv
// Shared constants, codes and control structs of the positional list store
package pls_pkg;

  localparam int CAPACITY  = 128;
  localparam int ADDR_W    = $clog2(CAPACITY);
  localparam int LEN_W     = $clog2(CAPACITY + 1);
  localparam int CMD_W     = 3;
  localparam int POS_W     = 8;
  localparam int CNT_W     = 8;
  localparam int DATA_W    = 32;
  localparam int STAT_W    = 2;
  localparam int OUT_LEN_W = 8;
  // wide enough for position - 1 + count and for length + 1
  localparam int CMP_W     = ((LEN_W > POS_W) ? LEN_W : POS_W) + 1;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 3'd0,
    CMD_DELETE = 3'd1,
    CMD_GET    = 3'd2,
    CMD_PRIOR  = 3'd3,
    CMD_NEXT   = 3'd4,
    CMD_DELRUN = 3'd5,
    CMD_CLEAR  = 3'd6
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // RAM read address source
  typedef enum logic [1:0] {
    RS_TARGET = 2'd0,
    RS_DOWN   = 2'd1,
    RS_UP     = 2'd2
  } rsel_t;

  typedef struct packed {
    logic  idle;
    logic  load;
    logic  check;
    rsel_t rsel;
    logic  capture;
    logic  init_down;
    logic  init_up;
    logic  wr_down;
    logic  wr_up;
    logic  write_new;
    logic  shrink;
    logic  clear_len;
    logic  emit;
  } ctl_t;

  typedef struct packed {
    logic in_valid;
    cmd_t cmd;
    logic range_err;
    logic full_err;
    logic cnt_zero;
    logic down_more;
    logic up_more;
    logic out_free;
  } dp_stat_t;

endpackage

### src/pls_in_if.sv
// Command channel of the positional list store
interface pls_in_if import pls_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [CMD_W-1:0]         command;
  logic [POS_W-1:0]         position;
  logic signed [DATA_W-1:0] value;
  logic [CNT_W-1:0]         count;

  modport source (output valid, command, position, value, count, input ready);
  modport sink (input valid, command, position, value, count, output ready);
endinterface

### src/pls_out_if.sv
// Result channel of the positional list store
interface pls_out_if import pls_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [STAT_W-1:0]        status;
  logic signed [DATA_W-1:0] value_out;
  logic [OUT_LEN_W-1:0]     length_out;
  logic                     is_empty;

  modport source (output valid, status, value_out, length_out, is_empty, input ready);
  modport sink (input valid, status, value_out, length_out, is_empty, output ready);
endinterface

### src/pls_ram.sv
// Generic single-write, single-read RAM with registered read data
module pls_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### src/pls_ctrl.sv
// Command sequencer: range check, element reads and shift loops
module pls_ctrl import pls_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  dp_stat_t stat,
  output ctl_t     ctl
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_RD,
    S_SHR,
    S_SHW,
    S_UPR,
    S_UPW,
    S_DONE
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    ctl       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        ctl.idle = 1'b1;
        if (stat.in_valid) begin
          ctl.load  = 1'b1;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        ctl.check = 1'b1;
        priority if (stat.range_err) begin
          state_nxt = S_DONE;
        end else begin
          unique case (stat.cmd)
            CMD_INSERT: begin
              if (stat.full_err) begin
                state_nxt = S_DONE;
              end else begin
                ctl.init_up = 1'b1;
                state_nxt   = S_UPR;
              end
            end
            CMD_DELETE, CMD_GET, CMD_PRIOR, CMD_NEXT: begin
              ctl.rsel  = RS_TARGET;
              state_nxt = S_RD;
            end
            CMD_DELRUN: begin
              if (stat.cnt_zero) begin
                state_nxt = S_DONE;
              end else begin
                ctl.init_down = 1'b1;
                state_nxt     = S_SHR;
              end
            end
            CMD_CLEAR: begin
              ctl.clear_len = 1'b1;
              state_nxt     = S_DONE;
            end
            default: state_nxt = S_DONE;
          endcase
        end
      end
      S_RD: begin
        ctl.capture = 1'b1;
        if (stat.cmd == CMD_DELETE) begin
          ctl.init_down = 1'b1;
          state_nxt     = S_SHR;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_SHR: begin
        if (stat.down_more) begin
          ctl.rsel  = RS_DOWN;
          state_nxt = S_SHW;
        end else begin
          ctl.shrink = 1'b1;
          state_nxt  = S_DONE;
        end
      end
      S_SHW: begin
        ctl.wr_down = 1'b1;
        state_nxt   = S_SHR;
      end
      S_UPR: begin
        if (stat.up_more) begin
          ctl.rsel  = RS_UP;
          state_nxt = S_UPW;
        end else begin
          ctl.write_new = 1'b1;
          state_nxt     = S_DONE;
        end
      end
      S_UPW: begin
        ctl.wr_up = 1'b1;
        state_nxt = S_UPR;
      end
      S_DONE: begin
        if (stat.out_free) begin
          ctl.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

### src/pls_dp.sv
// Datapath: item registers, length, element RAM, shift index and result register
`include "positional_list_store_macros.svh"
module pls_dp import pls_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  pls_in_if.sink    in_ch,
  pls_out_if.source out_ch,
  input  ctl_t      ctl,
  output dp_stat_t  stat
);

  cmd_t                cmd_r;
  logic [POS_W-1:0]    pos_r;
  logic [DATA_W-1:0]   val_r;
  logic [CNT_W-1:0]    cnt_r;
  logic [LEN_W-1:0]    len_r;
  logic [ADDR_W-1:0]   idx_r;
  status_t             status_r;
  logic [DATA_W-1:0]   result_r;

  logic                out_valid_r;
  status_t             out_status_r;
  logic [DATA_W-1:0]   out_value_r;
  logic [OUT_LEN_W-1:0] out_len_r;
  logic                out_empty_r;

  logic [CMP_W-1:0]    pos_x, len_x, cnt_x, idx_x, tgt_x, down_x;
  logic [ADDR_W-1:0]   tgt_addr;
  logic                range_err;
  logic                full_err;

  logic                ram_we;
  logic [ADDR_W-1:0]   ram_waddr;
  logic [ADDR_W-1:0]   ram_raddr;
  logic [DATA_W-1:0]   ram_wdata;
  logic [DATA_W-1:0]   ram_rdata;

  assign pos_x  = CMP_W'(pos_r);
  assign len_x  = CMP_W'(len_r);
  assign cnt_x  = CMP_W'(cnt_r);
  assign idx_x  = CMP_W'(idx_r);
  assign down_x = idx_x + cnt_x;

  always_comb begin
    unique case (cmd_r)
      CMD_INSERT: range_err = (pos_x == '0) || (pos_x > len_x + CMP_W'(1));
      CMD_DELETE,
      CMD_GET:    range_err = (pos_x == '0) || (pos_x > len_x);
      CMD_PRIOR:  range_err = (pos_x < CMP_W'(2)) || (pos_x > len_x);
      CMD_NEXT:   range_err = (pos_x == '0) || (pos_x >= len_x);
      CMD_DELRUN: range_err = (pos_x == '0) || (pos_x > len_x) ||
                              (pos_x - CMP_W'(1) + cnt_x > len_x);
      default:    range_err = 1'b0;
    endcase
  end

  assign full_err = (len_x >= CMP_W'(CAPACITY));

  always_comb begin
    unique case (cmd_r)
      CMD_PRIOR: tgt_x = pos_x - CMP_W'(2);
      CMD_NEXT:  tgt_x = pos_x;
      default:   tgt_x = pos_x - CMP_W'(1);
    endcase
  end
  assign tgt_addr = tgt_x[ADDR_W-1:0];

  always_comb begin
    unique case (ctl.rsel)
      RS_DOWN: ram_raddr = down_x[ADDR_W-1:0];
      RS_UP:   ram_raddr = idx_r - ADDR_W'(1);
      default: ram_raddr = tgt_addr;
    endcase
  end

  // the new value lands at position - 1 once the upper entries have moved
  assign ram_we    = ctl.wr_down || ctl.wr_up || ctl.write_new;
  assign ram_waddr = ctl.write_new ? tgt_addr : idx_r;
  assign ram_wdata = ctl.write_new ? val_r : ram_rdata;

  pls_ram #(
    .WIDTH (DATA_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd_r <= cmd_t'(in_ch.command);
      pos_r <= in_ch.position;
      val_r <= in_ch.value;
      cnt_r <= in_ch.count;
    end else if (ctl.init_down && cmd_r == CMD_DELETE) begin
      cnt_r <= CNT_W'(1);
    end

    if (ctl.check) begin
      result_r <= '0;
      if (range_err) begin
        status_r <= ST_RANGE;
      end else if (cmd_r == CMD_INSERT && full_err) begin
        status_r <= ST_FULL;
      end else begin
        status_r <= ST_OK;
      end
    end else if (ctl.capture) begin
      result_r <= ram_rdata;
    end

    if (ctl.init_down) begin
      idx_r <= tgt_addr;
    end else if (ctl.init_up) begin
      idx_r <= len_r[ADDR_W-1:0];
    end else if (ctl.wr_down) begin
      idx_r <= idx_r + ADDR_W'(1);
    end else if (ctl.wr_up) begin
      idx_r <= idx_r - ADDR_W'(1);
    end

    if (ctl.emit) begin
      out_status_r <= status_r;
      out_value_r  <= result_r;
      out_len_r    <= OUT_LEN_W'(len_r);
      out_empty_r  <= (len_r == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (ctl.clear_len) begin
        len_r <= '0;
      end else if (ctl.write_new) begin
        len_r <= len_r + LEN_W'(1);
      end else if (ctl.shrink) begin
        len_r <= len_r - LEN_W'(cnt_r);
      end

      if (ctl.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign in_ch.ready       = ctl.idle;
  assign out_ch.valid      = out_valid_r;
  assign out_ch.status     = out_status_r;
  assign out_ch.value_out  = out_value_r;
  assign out_ch.length_out = out_len_r;
  assign out_ch.is_empty   = out_empty_r;

  assign stat.in_valid  = in_ch.valid;
  assign stat.cmd       = cmd_r;
  assign stat.range_err = range_err;
  assign stat.full_err  = full_err;
  assign stat.cnt_zero  = (cnt_r == '0);
  assign stat.down_more = (down_x < len_x);
  assign stat.up_more   = (idx_x >= pos_x);
  assign stat.out_free  = !out_valid_r || out_ch.ready;

  `PLS_ASSERT(a_len_bound, CMP_W'(len_r) <= CMP_W'(CAPACITY), "list length above capacity")
  `PLS_ASSERT_IMP(a_idle_no_write, ctl.idle, !ram_we, "element store written while idle")
  `PLS_ASSERT(a_ins_grow, ctl.write_new |=> len_r == $past(len_r) + LEN_W'(1), "insert did not grow length")
  `PLS_ASSERT(a_emit_valid, ctl.emit |=> out_valid_r, "result register not loaded")

endmodule

### src/positional_list_store.sv
// Positional list store: ordered list of signed 32-bit entries, 1-based positions
//
// in_ch  : command, position, value, count; taken when valid and ready are high.
//          ready is high only while the sequencer is idle, one item at a time.
// out_ch : status, value_out, length_out, is_empty; one result per item, held
//          in an output register until the receiver takes it.
// Sequence: an accepted item is loaded and range-checked; a rejected command, clear,
//          the unused code and a zero-count delete run then go to the result step.
//          Get, prior and next first read their entry. Insert moves the entries up
//          (length - position + 1 of them), then writes the new value; delete reads
//          its entry, then delete and delete run move entries down (length - position
//          - count + 1, count being 1 for delete). The element store has one write and
//          one registered read port, so each moved entry is first read, then written.
// Throughput: the next item is accepted the cycle after the result is loaded,
//          even while that result still waits in the output register.
// Reset (rst_n low, synchronous): the list is emptied and no result is pending;
//          the element store is not cleared, entries past the length are never read.
// Stall: while out_ch.ready is low the result holds; a second finished result
//          waits inside the block and no further item is taken.
module positional_list_store import pls_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  pls_in_if.sink    in_ch,
  pls_out_if.source out_ch
);

  ctl_t     ctl;
  dp_stat_t stat;

  pls_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .stat  (stat),
    .ctl   (ctl)
  );

  pls_dp u_dp (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .ctl    (ctl),
    .stat   (stat)
  );

endmodule

### dv/tb.sv
// Testbench for positional_list_store: random and directed list commands checked against a local model
module tb import pls_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 3'd7;
  localparam int SHADOW_GEN  = 0;  // list image tracked while building stimulus
  localparam int SHADOW_CHK  = 1;  // list image advanced on accepted items
  localparam int STALL_LIMIT = 3000;
  localparam int LONG_HOLD   = 400;
  localparam int RANDOM_ITEMS = 575;

  typedef struct {
    logic [CMD_W-1:0]         command;
    logic [POS_W-1:0]         position;
    logic signed [DATA_W-1:0] value;
    logic [CNT_W-1:0]         count;
    bit                       drain_first;
  } list_cmd_t;

  typedef struct {
    logic [STAT_W-1:0]        status;
    logic signed [DATA_W-1:0] value_out;
    logic [OUT_LEN_W-1:0]     length_out;
    logic                     is_empty;
  } list_reply_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                     drv_valid = 1'b0;
  logic [CMD_W-1:0]         drv_command = '0;
  logic [POS_W-1:0]         drv_position = '0;
  logic signed [DATA_W-1:0] drv_value = '0;
  logic [CNT_W-1:0]         drv_count = '0;
  logic                     mon_ready = 1'b0;

  pls_in_if  in_ch ();
  pls_out_if out_ch ();

  assign in_ch.valid    = drv_valid;
  assign in_ch.command  = drv_command;
  assign in_ch.position = drv_position;
  assign in_ch.value    = drv_value;
  assign in_ch.count    = drv_count;
  assign out_ch.ready   = mon_ready;

  positional_list_store dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #1 clk = ~clk;

  logic signed [DATA_W-1:0] cells [2][CAPACITY];
  int unsigned              list_len [2];

  list_cmd_t   pending_q[$];
  list_reply_t reply_q[$];
  list_cmd_t   cur_cmd;

  int  n_sent = 0;
  int  n_checked = 0;
  int  n_errors = 0;
  int  total_items = 0;
  int  n_range = 0;
  int  n_full = 0;
  int  peak_len = 0;
  int  cyc = 0;
  int  idle_cycles = 0;
  bit  tail_quiet = 1'b0;
  bit  calm;

  assign calm = ((cyc / 256) % 4) == 0;

  // Applies one command to list image `view` and returns the reply it produces.
  function automatic list_reply_t apply_command(input int view, input list_cmd_t c);
    list_reply_t r;
    int unsigned p;
    int unsigned n;
    int unsigned len;
    int unsigned j;
    r.status = ST_OK;
    r.value_out = '0;
    p = c.position;
    n = c.count;
    len = list_len[view];
    case (c.command)
      CMD_INSERT: begin
        if (p < 1 || p > len + 1) begin
          r.status = ST_RANGE;
        end else if (len >= CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          for (j = len; j > p - 1; j--) cells[view][j] = cells[view][j-1];
          cells[view][p-1] = c.value;
          len++;
        end
      end
      CMD_DELETE: begin
        if (p < 1 || p > len) begin
          r.status = ST_RANGE;
        end else begin
          r.value_out = cells[view][p-1];
          for (j = p - 1; j + 1 < len; j++) cells[view][j] = cells[view][j+1];
          len--;
        end
      end
      CMD_GET: begin
        if (p < 1 || p > len) r.status = ST_RANGE;
        else r.value_out = cells[view][p-1];
      end
      CMD_PRIOR: begin
        if (p < 2 || p > len) r.status = ST_RANGE;
        else r.value_out = cells[view][p-2];
      end
      CMD_NEXT: begin
        if (p < 1 || p >= len) r.status = ST_RANGE;
        else r.value_out = cells[view][p];
      end
      CMD_DELRUN: begin
        if (p < 1 || p > len || p - 1 + n > len) begin
          r.status = ST_RANGE;
        end else begin
          for (j = p - 1; j + n < len; j++) cells[view][j] = cells[view][j+n];
          len -= n;
        end
      end
      CMD_CLEAR: len = 0;
      default: ;
    endcase
    list_len[view] = len;
    r.length_out = len[OUT_LEN_W-1:0];
    r.is_empty = (len == 0);
    return r;
  endfunction

  task automatic queue_item(input logic [CMD_W-1:0] cmd, input int pos,
                            input logic signed [DATA_W-1:0] val, input int cnt,
                            input bit drain);
    list_cmd_t c;
    c.command = cmd;
    c.position = pos[POS_W-1:0];
    c.value = val;
    c.count = cnt[CNT_W-1:0];
    c.drain_first = drain;
    void'(apply_command(SHADOW_GEN, c));
    pending_q.push_back(c);
  endtask

  function automatic logic signed [DATA_W-1:0] random_value();
    case ($urandom_range(0, 15))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return '0;
      default: return $urandom;
    endcase
  endfunction

  // Mostly well-formed commands against the tracked length, some out of range.
  task automatic random_item(input int ins_pct, input bit drain);
    logic [CMD_W-1:0] cmd;
    int L;
    int lo;
    int hi;
    int pos;
    int cnt;
    int room;
    L = list_len[SHADOW_GEN];
    if ($urandom_range(0, 49) == 0) begin
      cmd = CMD_UNUSED;
    end else if ($urandom_range(0, 99) < ins_pct) begin
      cmd = CMD_INSERT;
    end else begin
      case ($urandom_range(0, 9))
        0, 1, 2: cmd = CMD_DELETE;
        3, 4:    cmd = CMD_GET;
        5:       cmd = CMD_PRIOR;
        6:       cmd = CMD_NEXT;
        7, 8:    cmd = CMD_DELRUN;
        default: cmd = ($urandom_range(0, 2) == 0) ? CMD_CLEAR : CMD_GET;
      endcase
    end
    lo = 1;
    hi = L;
    case (cmd)
      CMD_INSERT: hi = L + 1;
      CMD_PRIOR:  lo = 2;
      CMD_NEXT:   hi = L - 1;
      default: ;
    endcase
    if (hi > CAPACITY) hi = CAPACITY;
    if (hi < lo || $urandom_range(0, 99) < 15) pos = $urandom_range(0, CAPACITY);
    else pos = $urandom_range(lo, hi);
    room = L - pos + 1;
    if (cmd == CMD_DELRUN && pos >= 1 && room >= 0 && $urandom_range(0, 99) < 85) begin
      if ($urandom_range(0, 7) == 0) cnt = room;
      else cnt = $urandom_range(0, (room < 6) ? room : 6);
    end else begin
      cnt = $urandom_range(0, CAPACITY);
    end
    queue_item(cmd, pos, random_value(), cnt, drain);
  endtask

  // Driver: offers pending items, holds an item until taken, random gaps.
  int gap_left = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      drv_valid <= 1'b0;
      gap_left = 0;
    end else begin
      tail_quiet <= (pending_q.size() < 60);
      if (drv_valid && in_ch.ready) begin
        list_reply_t r;
        r = apply_command(SHADOW_CHK, cur_cmd);
        reply_q.push_back(r);
        n_sent++;
        if (r.status == ST_RANGE) n_range++;
        if (r.status == ST_FULL) n_full++;
        if (list_len[SHADOW_CHK] > peak_len) peak_len = list_len[SHADOW_CHK];
      end
      if (drv_valid && !in_ch.ready) begin
        // item still on offer, keep it
      end else if (gap_left > 0) begin
        gap_left--;
        drv_valid <= 1'b0;
      end else if (pending_q.size() == 0 ||
                   (pending_q[0].drain_first && n_sent != n_checked)) begin
        drv_valid <= 1'b0;
      end else if (!tail_quiet && !calm && $urandom_range(0, 5) == 0) begin
        gap_left = $urandom_range(1, 10) - 1;
        drv_valid <= 1'b0;
      end else begin
        cur_cmd = pending_q.pop_front();
        drv_valid    <= 1'b1;
        drv_command  <= cur_cmd.command;
        drv_position <= cur_cmd.position;
        drv_value    <= cur_cmd.value;
        drv_count    <= cur_cmd.count;
      end
    end
  end

  // Monitor: compares each result with the oldest expected reply.
  int  hold_left = 0;
  bit  long_hold_done = 1'b0;
  always @(posedge clk) begin
    if (!rst_n) begin
      mon_ready <= 1'b0;
      hold_left = 0;
    end else begin
      if (out_ch.valid && mon_ready) begin
        if (reply_q.size() == 0) begin
          $error("result with no expected reply waiting");
          n_errors++;
        end else begin
          list_reply_t want;
          want = reply_q.pop_front();
          if (out_ch.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_ch.status);
            n_errors++;
          end
          if (out_ch.value_out !== want.value_out) begin
            $error("value_out: expected %0d, got %0d", want.value_out, out_ch.value_out);
            n_errors++;
          end
          if (out_ch.length_out !== want.length_out) begin
            $error("length_out: expected %0d, got %0d", want.length_out, out_ch.length_out);
            n_errors++;
          end
          if (out_ch.is_empty !== want.is_empty) begin
            $error("is_empty: expected %0d, got %0d", want.is_empty, out_ch.is_empty);
            n_errors++;
          end
          n_checked <= n_checked + 1;
        end
      end
      // one long hold-off so the block backs up and stalls its input
      if (!long_hold_done && n_checked >= 150 && drv_valid) begin
        long_hold_done = 1'b1;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        mon_ready <= 1'b0;
      end else if (!tail_quiet && !calm && $urandom_range(0, 5) == 0) begin
        hold_left = $urandom_range(1, 10) - 1;
        mon_ready <= 1'b0;
      end else begin
        mon_ready <= 1'b1;
      end
    end
  end

  // Watchdog: ends the run if nothing moves on either channel for too long.
  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int rand_items;
    int fills;
    int ins_pct;
    int burst;
    list_len[SHADOW_GEN] = 0;
    list_len[SHADOW_CHK] = 0;

    // directed: empty-list errors, value extremes, each command, edge positions
    queue_item(CMD_GET,    1, '0, 0, 1'b0);
    queue_item(CMD_DELETE, 1, '0, 0, 1'b0);
    queue_item(CMD_PRIOR,  2, '0, 0, 1'b0);
    queue_item(CMD_NEXT,   1, '0, 0, 1'b0);
    queue_item(CMD_DELRUN, 1, '0, 0, 1'b0);
    queue_item(CMD_INSERT, 0, 32'sd5, 0, 1'b0);
    queue_item(CMD_INSERT, 2, 32'sd6, 0, 1'b0);
    queue_item(CMD_INSERT, 1, 32'sh7fffffff, 0, 1'b0);
    queue_item(CMD_INSERT, 1, 32'sh80000000, 0, 1'b0);
    queue_item(CMD_INSERT, 3, -32'sd1, 0, 1'b0);
    queue_item(CMD_INSERT, 2, '0, 0, 1'b0);
    queue_item(CMD_GET,    4, '0, 0, 1'b0);
    queue_item(CMD_GET,    5, '0, 0, 1'b0);
    queue_item(CMD_PRIOR,  1, '0, 0, 1'b0);
    queue_item(CMD_PRIOR,  4, '0, 0, 1'b0);
    queue_item(CMD_NEXT,   4, '0, 0, 1'b0);
    queue_item(CMD_NEXT,   1, '0, 0, 1'b0);
    queue_item(CMD_DELETE, 1, '0, 0, 1'b0);
    queue_item(CMD_DELRUN, 2, '0, 0, 1'b0);
    queue_item(CMD_DELRUN, 2, '0, 3, 1'b0);
    queue_item(CMD_DELRUN, 2, '0, 2, 1'b0);
    queue_item(CMD_UNUSED, CAPACITY, 32'sh5a5a5a5a, CAPACITY, 1'b0);
    queue_item(CMD_DELRUN, CAPACITY, '0, CAPACITY, 1'b0);
    queue_item(CMD_CLEAR,  0, '0, 0, 1'b0);
    queue_item(CMD_INSERT, CAPACITY, 32'sd7, 0, 1'b0);

    rand_items = 0;
    fills = 0;
    while (rand_items < RANDOM_ITEMS) begin
      if (fills < 2 && $urandom_range(0, 9) < 2) begin
        // fill to capacity, probe the full list, then empty it in one run
        fills++;
        random_item(100, 1'b1);
        rand_items++;
        while (list_len[SHADOW_GEN] < CAPACITY) begin
          queue_item(CMD_INSERT, $urandom_range(1, list_len[SHADOW_GEN] + 1),
                     random_value(), 0, 1'b0);
          rand_items++;
        end
        queue_item(CMD_INSERT, 1, random_value(), 0, 1'b0);
        queue_item(CMD_INSERT, CAPACITY, random_value(), 0, 1'b0);
        queue_item(CMD_INSERT, 0, random_value(), 0, 1'b0);
        queue_item(CMD_GET, CAPACITY, '0, 0, 1'b0);
        queue_item(CMD_GET, 1, '0, 0, 1'b0);
        queue_item(CMD_PRIOR, CAPACITY, '0, 0, 1'b0);
        queue_item(CMD_NEXT, CAPACITY - 1, '0, 0, 1'b0);
        queue_item(CMD_NEXT, CAPACITY, '0, 0, 1'b0);
        queue_item(CMD_DELETE, CAPACITY, '0, 0, 1'b0);
        queue_item(CMD_INSERT, CAPACITY, random_value(), 0, 1'b0);
        queue_item(CMD_DELRUN, 1, '0, CAPACITY, 1'b0);
        rand_items += 11;
      end else begin
        case ($urandom_range(0, 2))
          0:       ins_pct = 65;
          1:       ins_pct = 40;
          default: ins_pct = 15;
        endcase
        for (burst = 0; burst < 30; burst++) begin
          random_item(ins_pct, burst == 0 && $urandom_range(0, 3) == 0);
          rand_items++;
        end
      end
    end
    total_items = pending_q.size();

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    wait (n_sent == total_items && n_checked == total_items);
    repeat (300) @(posedge clk);

    $display("Ran %0d commands including %0d capacity fills; %0d range and %0d full rejections.",
             total_items, fills, n_range, n_full);
    $display("Peak list length %0d of %0d, %0d field mismatches.", peak_len, CAPACITY, n_errors);
    if (n_errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
